[sv/tsct_pkg.sv]
// shared types, constants and rounding multiply for the sine/cosine/tangent unit
`default_nettype none
package tsct_pkg;

  localparam int IF_BITS = 29;
  localparam int TW      = 36;

  localparam logic [1:0] OP_SIN = 2'd0;
  localparam logic [1:0] OP_COS = 2'd1;
  localparam logic [1:0] OP_TAN = 2'd2;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef logic signed [TW-1:0] term_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
  } tag_t;

  localparam logic [63:0] ONE_U = 64'd1 << IF_BITS;

  localparam term_t C_ONE     = term_t'(ONE_U);
  localparam term_t C_F2      = term_t'((ONE_U + 64'd1) / 64'd2);
  localparam term_t C_F3      = term_t'((ONE_U + 64'd3) / 64'd6);
  localparam term_t C_F4      = term_t'((ONE_U + 64'd12) / 64'd24);
  localparam term_t C_F5      = term_t'((ONE_U + 64'd60) / 64'd120);
  localparam term_t C_F6      = term_t'((ONE_U + 64'd360) / 64'd720);
  localparam term_t C_F7      = term_t'((ONE_U + 64'd2520) / 64'd5040);
  localparam term_t C_F8      = term_t'((ONE_U + 64'd20160) / 64'd40320);
  localparam term_t C_F9      = term_t'((ONE_U + 64'd181440) / 64'd362880);
  localparam term_t C_F10     = term_t'((ONE_U + 64'd1814400) / 64'd3628800);

  localparam logic signed [2*TW-1:0] FM_HALF  = (2*TW)'(1) << (IF_BITS - 1);
  localparam logic signed [2*TW-1:0] FM_HALFM = FM_HALF - (2*TW)'(1);

  // product rounded to nearest at IF_BITS, ties away from zero
  function automatic term_t fmul(term_t a, term_t b);
    logic signed [2*TW-1:0] p;
    logic signed [2*TW-1:0] r;
    p = a * b;
    r = (p + (p[2*TW-1] ? FM_HALFM : FM_HALF)) >>> IF_BITS;
    return term_t'(r);
  endfunction

endpackage
`default_nettype wire

[sv/tsct_reduce.sv]
// range reduction of the angle into [-pi, pi], four pipeline stages
`default_nettype none
module tsct_reduce #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tsct_pkg::tag_t       tag_i,
  input  logic signed [31:0]   angle_i,
  output tsct_pkg::tag_t       tag_o,
  output logic signed [31:0]   x_o
);
  import tsct_pkg::*;

  localparam int RW = 36;
  localparam int RS = 50;
  localparam int SH = IF_BITS - FRAC_BITS;
  localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_U = (PI60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [63:0] TP_U = (PI60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
  localparam logic [63:0] RC_U = (64'd1 << RS) / TP_U;
  localparam logic signed [RW-1:0] PI_S = RW'(PI_U);
  localparam logic signed [RW-1:0] TP_S = RW'(TP_U);
  localparam logic signed [RW-1:0] RC_S = RW'(RC_U);

  tag_t tag1_q, tag2_q, tag3_q, tag4_q;
  logic signed [31:0]     v1_q, v2_q, v3_q;
  logic signed [2*RW-1:0] p1_q;
  logic signed [2*RW-1:0] p1_d;
  logic signed [RW-1:0]   u;
  logic signed [15:0]     k;
  logic signed [RW-1:0]   kp2_q, kp2_d;
  logic signed [RW-1:0]   r0, r1_d, r1_q;
  logic signed [RW-1:0]   v3s, r4;
  logic signed [31:0]     x4_q, x4_d;

  // quotient estimate by reciprocal
  assign u    = RW'(angle_i) + PI_S;
  assign p1_d = u * RC_S;
  assign k    = $signed(p1_q[RS+15:RS]);
  assign kp2_d = RW'(k * TP_S);

  // estimate may be one step off either way
  always_comb begin
    r0 = RW'(v2_q) - kp2_q;
    if (r0 < -PI_S) begin
      r1_d = r0 + TP_S;
    end else if (r0 >= TP_S - PI_S) begin
      r1_d = r0 - TP_S;
    end else begin
      r1_d = r0;
    end
  end

  // interval end depends on the side the angle came from
  always_comb begin
    v3s = RW'(v3_q);
    if (v3s > PI_S) begin
      if (r1_q > PI_S) begin
        r4 = r1_q - TP_S;
      end else if (r1_q <= PI_S - TP_S) begin
        r4 = r1_q + TP_S;
      end else begin
        r4 = r1_q;
      end
    end else if (v3s < -PI_S) begin
      r4 = r1_q;
    end else begin
      r4 = v3s;
    end
    x4_d = 32'(r4 <<< SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q  <= angle_i;
      p1_q  <= p1_d;
      v2_q  <= v1_q;
      kp2_q <= kp2_d;
      v3_q  <= v2_q;
      r1_q  <= r1_d;
      x4_q  <= x4_d;
    end
  end

  assign tag_o = tag4_q;
  assign x_o   = x4_q;

endmodule
`default_nettype wire

[sv/tsct_series.sv]
// horner evaluation of the sine and cosine series, seven pipeline stages
`default_nettype none
module tsct_series #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tsct_pkg::tag_t       tag_i,
  input  logic signed [31:0]   x_i,
  output tsct_pkg::tag_t       tag_o,
  output logic signed [31:0]   sin_o,
  output logic signed [31:0]   cos_o
);
  import tsct_pkg::*;

  localparam int SH = IF_BITS - FRAC_BITS;
  localparam term_t HS  = term_t'(1) <<< (SH - 1);
  localparam term_t HSM = HS - term_t'(1);
  localparam logic [63:0] EPS_U = ((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000;
  localparam term_t COS_EPS = term_t'(EPS_U);
  localparam term_t SIN_C [2:5] = '{C_F7, C_F5, C_F3, C_ONE};
  localparam term_t COS_C [2:6] = '{C_F8, C_F6, C_F4, C_F2, C_ONE};

  function automatic term_t rnd(term_t p);
    return (p + (p[TW-1] ? HSM : HS)) >>> SH;
  endfunction

  tag_t  tag_q [1:7];
  term_t x_q   [1:5];
  term_t x2_q  [1:5];
  term_t ts_q  [1:6];
  term_t tc_q  [1:6];
  logic signed [31:0] sin_q, cos_q, sin_d, cos_d;
  term_t cr, cmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 7; i++) begin
        tag_q[i] <= '0;
      end
    end else if (en_i) begin
      tag_q[1] <= tag_i;
      for (int i = 2; i <= 7; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[1]  <= TW'(x_i);
      x2_q[1] <= fmul(TW'(x_i), TW'(x_i));
      ts_q[1] <= C_F9;
      tc_q[1] <= C_F10;
    end
  end

  for (genvar i = 2; i <= 6; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tc_q[i] <= COS_C[i] - fmul(x2_q[i-1], tc_q[i-1]);
      end
    end
    if (i < 6) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[i]  <= x_q[i-1];
          x2_q[i] <= x2_q[i-1];
          ts_q[i] <= SIN_C[i] - fmul(x2_q[i-1], ts_q[i-1]);
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ts_q[i] <= fmul(x_q[i-1], ts_q[i-1]);
        end
      end
    end
  end

  // tiny cosine forced to zero
  always_comb begin
    sin_d = 32'(rnd(ts_q[6]));
    cr    = rnd(tc_q[6]);
    cmag  = cr[TW-1] ? -cr : cr;
    cos_d = (cmag < COS_EPS) ? 32'sd0 : 32'(cr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign tag_o = tag_q[7];
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

[sv/tsct_div.sv]
// pipelined radix-2 divider for tangent with clamping and result select
`default_nettype none
module tsct_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tsct_pkg::tag_t       tag_i,
  input  logic signed [31:0]   sin_i,
  input  logic signed [31:0]   cos_i,
  output tsct_pkg::tag_t       tag_o,
  output logic signed [31:0]   value_o,
  output logic                 saturated_o
);
  import tsct_pkg::*;

  localparam int DW = FRAC_BITS + 1;
  localparam int NW = 2 * FRAC_BITS + 1;
  localparam int HW = NW - 32;
  localparam int NS = 16;

  typedef struct packed {
    logic czero;
    logic spos;
    logic ovf;
    logic neg;
  } dflag_t;

  tag_t               tag_q  [0:NS];
  dflag_t             flag_q [0:NS];
  logic [DW-1:0]      rem_q  [0:NS];
  logic [DW-1:0]      d_q    [0:NS];
  logic [31:0]        low_q  [0:NS];
  logic [31:0]        quo_q  [0:NS];
  logic signed [31:0] res_q  [0:NS];

  logic [31:0]        sabs, cabs;
  logic [DW-1:0]      sm, cm;
  logic [NW-1:0]      num;
  logic [HW-1:0]      hi;
  dflag_t             flag_d;
  logic signed [31:0] res_d;

  always_comb begin
    sabs = sin_i[31] ? 32'(-sin_i) : 32'(sin_i);
    cabs = cos_i[31] ? 32'(-cos_i) : 32'(cos_i);
    sm   = sabs[DW-1:0];
    cm   = cabs[DW-1:0];
    num  = NW'(sm) << FRAC_BITS;
    hi   = num[NW-1:32];
    flag_d.czero = (cos_i == 32'sd0);
    flag_d.spos  = !sin_i[31] && (sin_i != 32'sd0);
    flag_d.ovf   = {{DW{1'b0}}, hi} >= {{HW{1'b0}}, cm};
    flag_d.neg   = sin_i[31] ^ cos_i[31];
    case (tag_i.op)
      OP_SIN:  res_d = sin_i;
      OP_COS:  res_d = cos_i;
      default: res_d = 32'sd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) begin
        tag_q[i] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i <= NS; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flag_q[0] <= flag_d;
      rem_q[0]  <= DW'(hi);
      d_q[0]    <= cm;
      low_q[0]  <= num[31:0];
      quo_q[0]  <= '0;
      res_q[0]  <= res_d;
    end
  end

  // two quotient bits per stage
  for (genvar j = 1; j <= NS; j++) begin : g_div
    logic [DW:0]   a1, a2;
    logic [DW-1:0] r1, r2;
    logic          b1, b2;

    always_comb begin
      a1 = {rem_q[j-1], low_q[j-1][31]};
      b1 = a1 >= {1'b0, d_q[j-1]};
      r1 = b1 ? DW'(a1 - {1'b0, d_q[j-1]}) : DW'(a1);
      a2 = {r1, low_q[j-1][30]};
      b2 = a2 >= {1'b0, d_q[j-1]};
      r2 = b2 ? DW'(a2 - {1'b0, d_q[j-1]}) : DW'(a2);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flag_q[j] <= flag_q[j-1];
        rem_q[j]  <= r2;
        d_q[j]    <= d_q[j-1];
        low_q[j]  <= {low_q[j-1][29:0], 2'b00};
        quo_q[j]  <= {quo_q[j-1][29:0], b1, b2};
        res_q[j]  <= res_q[j-1];
      end
    end
  end

  tag_t               tag_out_q;
  logic signed [31:0] val_q, val_d;
  logic               sat_q, sat_d;
  logic [31:0]        qm;
  dflag_t             fl;

  always_comb begin
    qm    = quo_q[NS];
    fl    = flag_q[NS];
    val_d = res_q[NS];
    sat_d = 1'b0;
    if (tag_q[NS].op == OP_TAN) begin
      if (fl.czero) begin
        val_d = fl.spos ? VAL_MAX : VAL_MIN;
        sat_d = 1'b1;
      end else if (fl.ovf) begin
        val_d = fl.neg ? VAL_MIN : VAL_MAX;
        sat_d = 1'b1;
      end else if (fl.neg) begin
        if (qm > 32'h80000000) begin
          val_d = VAL_MIN;
          sat_d = 1'b1;
        end else begin
          val_d = $signed(32'(-qm));
        end
      end else begin
        if (qm[31]) begin
          val_d = VAL_MAX;
          sat_d = 1'b1;
        end else begin
          val_d = $signed(qm);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_out_q <= '0;
    end else if (en_i) begin
      tag_out_q <= tag_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      sat_q <= sat_d;
    end
  end

  assign tag_o       = tag_out_q;
  assign value_o     = val_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

[sv/taylor_sin_cos_tan_unit.sv]
// top level of the fixed-point sine, cosine and tangent unit
//
// request channel: operation_i (0 sine, 1 cosine, 2 tangent) and a signed
// angle_i in radians with FRAC_BITS fraction bits, taken when in_valid_i is
// high and in_stall_o is low. result channel: value_o (same format) and
// saturated_o, handed over when out_valid_o is high and out_stall_i is low.
// one request per cycle is accepted while in_stall_o is low.
// every request passes through range reduction, the two horner series and
// the 2-bit-per-stage tangent divider; every operation takes the same path
// so results leave in request order.
// reset clears all valid bits; payload registers are left as they are.
// when the receiver stalls, the result leaving the pipeline drops into a
// one-entry skid register and in_stall_o rises on the next cycle, freezing
// the whole pipeline until that entry is taken; nothing is lost or repeated.
// in_stall_o comes straight from a register.
`default_nettype none
module taylor_sin_cos_tan_unit #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               saturated_o
);
  import tsct_pkg::*;

  logic               en;
  tag_t               tag_in, tag_red, tag_ser, tag_div;
  logic signed [31:0] x_red, sin_v, cos_v, d_value;
  logic               d_sat;
  logic               skid_v_q;
  logic signed [31:0] skid_value_q;
  logic               skid_sat_q;

  assign en           = !skid_v_q;
  assign in_stall_o   = skid_v_q;
  assign tag_in.valid = in_valid_i && en;
  assign tag_in.op    = operation_i;

  tsct_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (tag_in),
    .angle_i (angle_i),
    .tag_o   (tag_red),
    .x_o     (x_red)
  );

  tsct_series #(.FRAC_BITS(FRAC_BITS)) u_series (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_red),
    .x_i    (x_red),
    .tag_o  (tag_ser),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  tsct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .tag_i       (tag_ser),
    .sin_i       (sin_v),
    .cos_i       (cos_v),
    .tag_o       (tag_div),
    .value_o     (d_value),
    .saturated_o (d_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (tag_div.valid && out_stall_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && tag_div.valid && out_stall_i) begin
      skid_value_q <= d_value;
      skid_sat_q   <= d_sat;
    end
  end

  assign out_valid_o = skid_v_q || tag_div.valid;
  assign value_o     = skid_v_q ? skid_value_q : d_value;
  assign saturated_o = skid_v_q ? skid_sat_q : d_sat;

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_stall_i))
    else $error("skid register filled without a stall");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> !skid_v_q)
    else $error("skid register not drained after handover");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (value_o == VAL_MAX || value_o == VAL_MIN))
    else $error("saturated result not at a range end");

endmodule
`default_nettype wire
